// File: rtl/core/nalepr_pkg.sv
// Package for the NAL emulation prevention remover.
// Holds the word types, codes, limits and the trailing-zero helper.
// No dependencies.
package nalepr_pkg;

	localparam int unsigned MAX_UNIT_BYTES = 1048576;
	localparam int unsigned HEADER_BYTES   = 1;

	localparam logic [7:0]  EPB_VALUE      = 8'h03;
	localparam logic [1:0]  ZERO_RUN_LIMIT = 2'd2;
	localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
	localparam logic [19:0] COUNT_CAP =
		((MAX_UNIT_BYTES - 1) < 32'h000F_FFFF) ? 20'(MAX_UNIT_BYTES - 1) : 20'hF_FFFF;

	typedef struct packed {
		logic [7:0] nal_byte;
		logic       last_byte;
	} nal_word_t;

	typedef struct packed {
		logic [31:0] packed_word;
		logic [2:0]  word_bytes;
		logic        end_of_unit;
		logic [19:0] payload_bytes;
		logic [23:0] sodb_bits;
	} res_word_t;

	// count of trailing zeros, eight for an all-zero byte
	function automatic logic [3:0] trailing_zeros8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 7; i >= 0; i--) begin
			if (b[i]) begin
				n = 4'(i);
			end
		end
		return n;
	endfunction

endpackage

// File: rtl/core/nal_emulation_prevention_remover_top.sv
// Top level of the NAL emulation prevention remover.
// Each byte is registered in the input register, then its result word in the result register.
// Throughput: one byte per cycle while nal_stall is low; at most one result word per byte.
// A unit's final result carries the payload byte count and the SODB bit length.
// Reset: arst_n clears all unit state and both valid flags at once; no clearing pass.
// Depends on nalepr_pkg, nalepr_core and nalepr_out_buf.
module nal_emulation_prevention_remover_top import nalepr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      nal_valid,
	output logic      nal_stall,
	input  nal_word_t nal_data,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_data
);

	logic      valid_s1;
	nal_word_t byte_s1;
	logic      room;
	logic      fire;
	logic      has_result;
	res_word_t result;

	assign fire      = valid_s1 && room;
	assign nal_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!nal_stall) begin
			valid_s1 <= nal_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (nal_valid && !nal_stall) begin
			byte_s1 <= nal_data;
		end
	end

	nalepr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.byte_s1    (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	nalepr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && has_result),
		.load_data (result),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// File: rtl/core/nalepr_core.sv
// Byte filter and word packer of the NAL emulation prevention remover.
// Holds the per-unit state and builds one result from the registered byte.
// Depends on nalepr_pkg.
module nalepr_core import nalepr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  nal_word_t byte_s1,
	output logic      has_result,
	output res_word_t result
);

	logic [31:0] acc_q;
	logic [1:0]  biw_q;
	logic [1:0]  zero_run_q;
	logic [19:0] kept_q;
	logic [7:0]  lkb_q;
	logic        header_seen_q;

	logic        keep;
	logic        full;
	logic [31:0] acc_shift;
	logic [31:0] acc_d;
	logic [1:0]  biw_d;
	logic [1:0]  zero_run_d;
	logic [19:0] kept_d;
	logic [7:0]  lkb_d;
	logic [31:0] flush_word;
	logic [20:0] kept_inc;
	logic [23:0] total_bits;
	logic [23:0] cut_bits;
	logic [23:0] sodb;

	always_comb begin
		keep       = 1'b1;
		zero_run_d = zero_run_q;
		kept_d     = kept_q;
		if (header_seen_q) begin
			if (zero_run_q >= ZERO_RUN_LIMIT && byte_s1.nal_byte == EPB_VALUE) begin
				keep       = 1'b0;
				zero_run_d = 2'd0;
			end else begin
				if (byte_s1.nal_byte == 8'd0) begin
					if (zero_run_q < ZERO_RUN_LIMIT) begin
						zero_run_d = zero_run_q + 2'd1;
					end
				end else begin
					zero_run_d = 2'd0;
				end
				if (kept_q < COUNT_CAP) begin
					kept_d = kept_q + 20'd1;
				end
			end
		end

		acc_shift = {acc_q[23:0], byte_s1.nal_byte};
		full      = keep && (biw_q == 2'd3);
		biw_d     = keep ? biw_q + 2'd1 : biw_q;
		acc_d     = keep ? (full ? 32'd0 : acc_shift) : acc_q;
		lkb_d     = keep ? byte_s1.nal_byte : lkb_q;
	end

	always_comb begin
		unique case (biw_d)
			2'd1:    flush_word = {acc_d[7:0], 24'd0};
			2'd2:    flush_word = {acc_d[15:0], 16'd0};
			2'd3:    flush_word = {acc_d[23:0], 8'd0};
			default: flush_word = 32'd0;
		endcase
		kept_inc   = {1'b0, kept_d} + 21'(HEADER_BYTES);
		total_bits = {kept_inc, 3'b000};
		cut_bits   = 24'(trailing_zeros8(lkb_d)) + 24'd1;
		sodb       = (total_bits > cut_bits) ? total_bits - cut_bits : 24'd0;
	end

	always_comb begin
		has_result = full || byte_s1.last_byte;
		result     = '0;
		if (byte_s1.last_byte) begin
			result.packed_word   = full ? acc_shift : flush_word;
			result.word_bytes    = full ? FULL_WORD_BYTES : {1'b0, biw_d};
			result.end_of_unit   = 1'b1;
			result.payload_bytes = kept_d;
			result.sodb_bits     = sodb;
		end else begin
			result.packed_word = acc_shift;
			result.word_bytes  = FULL_WORD_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			biw_q         <= '0;
			zero_run_q    <= '0;
			kept_q        <= '0;
			lkb_q         <= '0;
			header_seen_q <= 1'b0;
		end else if (fire) begin
			if (byte_s1.last_byte) begin
				acc_q         <= '0;
				biw_q         <= '0;
				zero_run_q    <= '0;
				kept_q        <= '0;
				lkb_q         <= '0;
				header_seen_q <= 1'b0;
			end else begin
				acc_q         <= acc_d;
				biw_q         <= biw_d;
				zero_run_q    <= zero_run_d;
				kept_q        <= kept_d;
				lkb_q         <= lkb_d;
				header_seen_q <= 1'b1;
			end
		end
	end

	a_unit_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && byte_s1.last_byte |=> !header_seen_q && biw_q == 2'd0 && kept_q == 20'd0)
		else $error("state not cleared after end of unit");

	a_mid_result_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_result && !byte_s1.last_byte |-> result.word_bytes == FULL_WORD_BYTES)
		else $error("mid-unit result without a full word");

	a_zero_run_sat: assert property (@(posedge clk) disable iff (!arst_n)
		zero_run_q <= ZERO_RUN_LIMIT)
		else $error("zero run beyond limit");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= COUNT_CAP)
		else $error("kept count beyond cap");

endmodule

// File: rtl/core/nalepr_out_buf.sv
// Result register of the NAL emulation prevention remover.
// Holds one result word until taken; reports room for the next one.
// Depends on nalepr_pkg.
module nalepr_out_buf import nalepr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  res_word_t load_data,
	output logic      room,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_data
);

	logic      valid_q;
	res_word_t data_q;

	assign room      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			data_q <= load_data;
		end
	end

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_stall |=> valid_q && $stable(data_q))
		else $error("stalled result lost or changed");

endmodule

// File: verif/nal_emulation_prevention_remover_top_tb.sv
`timescale 1ns / 100ps
// Testbench for nal_emulation_prevention_remover_top: random and directed NAL units in,
// packed result words checked against an in-bench predictor. Depends on nalepr_pkg.
module nal_emulation_prevention_remover_top_tb;
	import nalepr_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      nal_valid = 1'b0;
	logic      nal_stall;
	nal_word_t nal_data = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_word_t res_data;

	nal_emulation_prevention_remover_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal_valid (nal_valid),
		.nal_stall (nal_stall),
		.nal_data  (nal_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	nal_word_t pending_bytes[$];
	res_word_t expected_words[$];

	int   send_gap_pct = 0;
	int   stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_off = 1'b0;
	logic nal_taken = 1'b0;

	int words_queued = 0;
	int words_in = 0;
	int results_out = 0;
	int units_done = 0;
	int mismatches = 0;

	// predictor state
	logic [31:0] acc_word = '0;
	logic [1:0]  acc_bytes = '0;
	logic [1:0]  zrun = '0;
	logic [19:0] kept_cnt = '0;
	logic [7:0]  last_kept = '0;
	logic        header_done = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic strip_and_pack(input nal_word_t w);
		logic        keep;
		logic        full;
		logic [31:0] word_out;
		logic [2:0]  nb;
		res_word_t   r;
		int unsigned tz;
		int unsigned total_bits;
		int unsigned cut;
		int unsigned sodb;
		keep = 1'b1;
		full = 1'b0;
		word_out = '0;
		r = '0;
		if (header_done) begin
			if (zrun >= ZERO_RUN_LIMIT && w.nal_byte == EPB_VALUE) begin
				keep = 1'b0;
				zrun = '0;
			end else begin
				if (w.nal_byte == 8'h00) begin
					if (zrun < ZERO_RUN_LIMIT)
						zrun = zrun + 2'd1;
				end else begin
					zrun = '0;
				end
				if (kept_cnt < COUNT_CAP)
					kept_cnt = kept_cnt + 20'd1;
			end
		end
		header_done = 1'b1;
		if (keep) begin
			acc_word = {acc_word[23:0], w.nal_byte};
			last_kept = w.nal_byte;
			if (acc_bytes == 2'd3) begin
				full = 1'b1;
				word_out = acc_word;
				acc_word = '0;
				acc_bytes = '0;
			end else begin
				acc_bytes = acc_bytes + 2'd1;
			end
		end
		if (!w.last_byte) begin
			if (full) begin
				r.packed_word = word_out;
				r.word_bytes = FULL_WORD_BYTES;
				expected_words.push_back(r);
			end
			return;
		end
		tz = 0;
		while (tz < 8 && !last_kept[tz])
			tz++;
		total_bits = (kept_cnt + HEADER_BYTES) * 8;
		cut = tz + 1;
		sodb = (total_bits > cut) ? total_bits - cut : 0;
		if (full) begin
			nb = FULL_WORD_BYTES;
		end else begin
			nb = {1'b0, acc_bytes};
			word_out = (nb != 3'd0) ? acc_word << ((4 - nb) * 8) : '0;
		end
		r.packed_word = word_out;
		r.word_bytes = nb;
		r.end_of_unit = 1'b1;
		r.payload_bytes = kept_cnt;
		r.sodb_bits = sodb[23:0];
		expected_words.push_back(r);
		acc_word = '0;
		acc_bytes = '0;
		zrun = '0;
		kept_cnt = '0;
		last_kept = '0;
		header_done = 1'b0;
	endtask

	task automatic check_result(input res_word_t got);
		res_word_t want;
		if (expected_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word %h", got);
			return;
		end
		want = expected_words.pop_front();
		results_out++;
		if (got.end_of_unit === 1'b1)
			units_done++;
		if (got.packed_word !== want.packed_word || got.word_bytes !== want.word_bytes ||
				got.end_of_unit !== want.end_of_unit ||
				got.payload_bytes !== want.payload_bytes ||
				got.sodb_bits !== want.sodb_bits) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: word %h/%h bytes %0d/%0d end %b/%b payload %0d/%0d sodb %0d/%0d",
					got.packed_word, want.packed_word, got.word_bytes, want.word_bytes,
					got.end_of_unit, want.end_of_unit, got.payload_bytes, want.payload_bytes,
					got.sodb_bits, want.sodb_bits);
		end
	endtask

	// monitor: sample handshakes, predict and check
	always @(posedge clk) begin
		if (arst_n) begin
			nal_taken <= nal_valid && !nal_stall;
			if (nal_valid && !nal_stall) begin
				strip_and_pack(nal_data);
				words_in++;
			end
			if (res_valid && !res_stall)
				check_result(res_data);
		end else begin
			nal_taken <= 1'b0;
		end
	end

	// driver: hold a stalled word, else advance or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			nal_valid <= 1'b0;
		end else if (!nal_valid || nal_taken) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nal_valid <= 1'b1;
				nal_data <= pending_bytes.pop_front();
			end else begin
				nal_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		res_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	// long receiver hold-off
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d result words still pending", expected_words.size());
		$display("status: fail");
		$finish;
	end

	task automatic queue_word(input logic [7:0] b, input logic last);
		nal_word_t w;
		w.nal_byte = b;
		w.last_byte = last;
		pending_bytes.push_back(w);
		words_queued++;
	endtask

	function automatic logic [7:0] pick_byte(input bit uniform);
		int unsigned r;
		r = $urandom_range(99);
		if (uniform || r >= 62)
			return 8'($urandom_range(255));
		if (r < 35)
			return 8'h00;
		if (r < 55)
			return EPB_VALUE;
		return (r < 58) ? 8'h80 : 8'h01;
	endfunction

	task automatic queue_unit();
		int len;
		bit uniform;
		uniform = ($urandom_range(4) == 0);
		len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 0);
		queue_word(8'($urandom_range(255)), len == 0);
		for (int i = 1; i <= len; i++)
			queue_word(pick_byte(uniform), i == len);
	endtask

	task automatic wait_drain();
		while (pending_bytes.size() != 0 || nal_valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int gap, input int stall, input int n);
		int target;
		send_gap_pct = gap;
		stall_pct = stall;
		target = words_queued + n;
		while (words_queued < target)
			queue_unit();
		wait_drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header-only unit
		queue_word(8'hFF, 1'b1);
		// zero header, drops after two or more zeros, all-zero last byte
		queue_word(8'h00, 1'b0);
		queue_word(8'h03, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h03, 1'b0);
		queue_word(8'h03, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h03, 1'b0);
		queue_word(8'h00, 1'b1);
		// final byte dropped with nothing pending
		queue_word(8'h67, 1'b0);
		queue_word(8'h11, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h00, 1'b0);
		queue_word(8'h03, 1'b1);
		// final byte completes a word
		queue_word(8'h41, 1'b0);
		queue_word(8'hAA, 1'b0);
		queue_word(8'hBB, 1'b0);
		queue_word(8'hCC, 1'b1);
		// bit length clamped at zero
		queue_word(8'h00, 1'b1);
		wait_drain();

		run_phase(0, 0, 340);
		run_phase(45, 0, 340);
		run_phase(0, 45, 340);
		run_phase(10, 10, 340);
		hold_req = 1'b1;
		run_phase(0, 0, 120);

		repeat (10) @(posedge clk);
		$display("Sent %0d input words in %0d units; checked %0d result words.",
			words_in, units_done, results_out);
		$display("Idle mixes: none, sender, receiver, both, plus a 300-cycle receiver hold-off.");
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d result words missing", mismatches,
				expected_words.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
